// ===== src/ihdp_pkg.sv =====
// Package for the image header dimension parser: sizes, format codes,
// header signatures and the JPEG walker status record.
// No dependencies.
`default_nettype none

package ihdp_pkg;

    // Bytes of the file that are looked at; later bytes only end the file.
    localparam int BUFFER_BYTES = 65536;
    localparam int POS_W        = $clog2(BUFFER_BYTES + 1);

    // Leading bytes kept for the signature and dimension fields.
    localparam int HDR_LEN   = 30;
    localparam int HDR_IDX_W = $clog2(HDR_LEN);

    localparam int MIN_BYTES      = 26;
    localparam int MIN_WEBP_BYTES = 30;
    localparam int SOF_SPAN       = 10;

    localparam logic [2:0] FMT_NONE = 3'd0;
    localparam logic [2:0] FMT_PNG  = 3'd1;
    localparam logic [2:0] FMT_GIF  = 3'd2;
    localparam logic [2:0] FMT_BMP  = 3'd3;
    localparam logic [2:0] FMT_JPEG = 3'd4;
    localparam logic [2:0] FMT_WEBP = 3'd5;

    localparam logic [63:0] SIG_PNG  = 64'h89504E470D0A1A0A;
    localparam logic [31:0] SIG_IHDR = 32'h49484452;
    localparam logic [47:0] SIG_GIF7 = 48'h474946383761;
    localparam logic [47:0] SIG_GIF9 = 48'h474946383961;
    localparam logic [15:0] SIG_BMP  = 16'h424D;
    localparam logic [15:0] SIG_SOI  = 16'hFFD8;
    localparam logic [31:0] SIG_RIFF = 32'h52494646;
    localparam logic [31:0] SIG_WEBP = 32'h57454250;
    localparam logic [31:0] SIG_VP8X = 32'h56503858;
    localparam logic [31:0] SIG_VP8S = 32'h56503820;
    localparam logic [31:0] SIG_VP8L = 32'h5650384C;

    localparam logic [13:0] VP8_DIM_MASK = 14'h3fff;

    typedef struct packed {
        logic             sof_found;
        logic             failed;
        logic [POS_W-1:0] sof_pos;
        logic [15:0]      width;
        logic [15:0]      height;
    } t_jpeg_status;

endpackage

`default_nettype wire

// ===== src/ihdp_jpeg_walk.sv =====
// JPEG marker walker: follows segment lengths byte by byte up to the first
// SOF marker and captures its height and width. Depends on ihdp_pkg.
`default_nettype none

module ihdp_jpeg_walk (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_feed,
    input  wire logic                      i_clear,
    input  wire logic [ihdp_pkg::POS_W-1:0] i_pos,
    input  wire logic [7:0]                i_byte,
    output ihdp_pkg::t_jpeg_status         o_status
);
    import ihdp_pkg::*;

    localparam logic [2:0] PH_SCAN = 3'd0;
    localparam logic [2:0] PH_MARK = 3'd1;
    localparam logic [2:0] PH_LENH = 3'd2;
    localparam logic [2:0] PH_LENL = 3'd3;
    localparam logic [2:0] PH_SKIP = 3'd4;
    localparam logic [2:0] PH_SOF  = 3'd5;
    localparam logic [2:0] PH_DONE = 3'd6;

    logic [2:0]       r_phase,  n_phase;
    logic [15:0]      r_remain, n_remain;
    logic [POS_W-1:0] r_marker, n_marker;
    logic [7:0]       r_len_hi, n_len_hi;
    t_jpeg_status     r_stat,   n_stat;

    always_comb begin
        logic [15:0]      seg;
        logic [15:0]      rem_dec;
        logic [POS_W-1:0] off;
        seg      = {r_len_hi, i_byte};
        rem_dec  = r_remain - 16'd1;
        off      = i_pos - r_stat.sof_pos;
        n_phase  = r_phase;
        n_remain = r_remain;
        n_marker = r_marker;
        n_len_hi = r_len_hi;
        n_stat   = r_stat;
        if (i_feed) begin
            case (r_phase)
                PH_SCAN: begin
                    if (i_byte == 8'hFF) begin
                        n_marker = i_pos;
                        n_phase  = PH_MARK;
                    end
                end
                PH_MARK: begin
                    if (i_byte == 8'hFF) begin
                        n_marker = i_pos;
                    end else if (i_byte == 8'hD8 || i_byte == 8'hD9 || i_byte == 8'h01
                                 || (i_byte >= 8'hD0 && i_byte <= 8'hD7)) begin
                        // standalone markers carry no length
                        n_phase = PH_SCAN;
                    end else if (i_byte >= 8'hC0 && i_byte <= 8'hCF && i_byte != 8'hC4
                                 && i_byte != 8'hC8 && i_byte != 8'hCC) begin
                        n_stat.sof_found = 1'b1;
                        n_stat.sof_pos   = r_marker;
                        n_phase          = PH_SOF;
                    end else begin
                        n_phase = PH_LENH;
                    end
                end
                PH_LENH: begin
                    n_len_hi = i_byte;
                    n_phase  = PH_LENL;
                end
                PH_LENL: begin
                    if (seg < 16'd2) begin
                        n_stat.failed = 1'b1;
                        n_phase       = PH_DONE;
                    end else if (seg == 16'd2) begin
                        n_phase = PH_SCAN;
                    end else begin
                        n_remain = seg - 16'd2;
                        n_phase  = PH_SKIP;
                    end
                end
                PH_SKIP: begin
                    n_remain = rem_dec;
                    if (rem_dec == 16'd0) begin
                        n_phase = PH_SCAN;
                    end
                end
                PH_SOF: begin
                    if (off == POS_W'(5)) begin
                        n_stat.height[15:8] = i_byte;
                    end else if (off == POS_W'(6)) begin
                        n_stat.height[7:0] = i_byte;
                    end else if (off == POS_W'(7)) begin
                        n_stat.width[15:8] = i_byte;
                    end else if (off == POS_W'(8)) begin
                        n_stat.width[7:0] = i_byte;
                        n_phase           = PH_DONE;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    // Status including the current beat, for the end-of-file decision.
    assign o_status = n_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_phase  <= PH_SCAN;
            r_remain <= '0;
            r_marker <= '0;
            r_len_hi <= '0;
            r_stat   <= '0;
        end else begin
            r_phase  <= n_phase;
            r_remain <= n_remain;
            r_marker <= n_marker;
            r_len_hi <= n_len_hi;
            r_stat   <= n_stat;
        end
    end

endmodule

`default_nettype wire

// ===== src/image_header_dimension_parser_core.sv =====
// Image header dimension parser, top level: input register, header byte
// store, JPEG walker and the end-of-file result register.
// Depends on ihdp_pkg and ihdp_jpeg_walk.
//
// Usage:
//   Input channel (i_valid / o_ready) carries one file byte per beat, in file
//   order, with i_last_byte set on the final byte. Output channel (o_valid /
//   i_ready) carries one result per file: size_ok, format code, width, height.
//   Only the first BUFFER_BYTES bytes are examined; later bytes are counted
//   for nothing but the last flag.
//   Throughput: one byte per cycle while no last byte is held back (see Stall).
//   Each byte waits in the input register and updates the header store and
//   JPEG walker from there. Result path: the input register loads the last
//   byte on acceptance, and the result register loads from it once that byte
//   can advance; o_valid rises from the result register.
//   Stall: while a result waits in the output register, non-last bytes of the
//   next file keep flowing; a further last byte holds in the input register
//   until the waiting result is taken.
//   Reset: synchronous, active low; clears both valids, the byte counter and
//   the JPEG walker. The byte counter and walker also clear after each result.
`default_nettype none

module image_header_dimension_parser_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_byte,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_size_ok,
    output logic [2:0]       o_image_format,
    output logic [30:0]      o_pixel_width,
    output logic [30:0]      o_pixel_height
);
    import ihdp_pkg::*;

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_last;
    logic             s1_go;

    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic             in_buf;
    logic             hdr_wr;
    logic [7:0]       r_hdr [HDR_LEN];
    logic [7:0]       w_hdr [HDR_LEN];

    t_jpeg_status     jpeg_stat;

    logic             r_out_valid;
    logic             r_ok;
    logic [2:0]       r_fmt;
    logic [30:0]      r_width;
    logic [30:0]      r_height;
    logic             n_ok;
    logic [2:0]       n_fmt;
    logic [30:0]      n_width;
    logic [30:0]      n_height;

    // A last beat advances only when the result register can take it.
    assign s1_go   = r_in_valid && (!r_in_last || !r_out_valid || i_ready);
    assign o_ready = !r_in_valid || s1_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_in_valid <= 1'b1;
        end else if (s1_go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    assign in_buf = r_pos < POS_W'(BUFFER_BYTES);
    assign n_pos  = in_buf ? r_pos + POS_W'(1) : r_pos;
    assign hdr_wr = in_buf && (r_pos < POS_W'(HDR_LEN));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (s1_go) begin
            r_pos <= r_in_last ? '0 : n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && hdr_wr) begin
            r_hdr[r_pos[HDR_IDX_W-1:0]] <= r_in_byte;
        end
    end

    // Header view with the current beat already in place.
    for (genvar k = 0; k < HDR_LEN; k++) begin : g_hdr
        assign w_hdr[k] = (hdr_wr && r_pos == POS_W'(k)) ? r_in_byte : r_hdr[k];
    end

    ihdp_jpeg_walk u_jpeg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_feed   (s1_go && in_buf && (r_pos >= POS_W'(2))),
        .i_clear  (s1_go && r_in_last),
        .i_pos    (r_pos),
        .i_byte   (r_in_byte),
        .o_status (jpeg_stat)
    );

    always_comb begin
        logic [31:0]  be_w;
        logic [31:0]  be_h;
        logic [15:0]  gif_w;
        logic [15:0]  gif_h;
        logic [31:0]  bmp_w;
        logic [31:0]  bmp_raw;
        logic [31:0]  bmp_h;
        logic [31:0]  vp8l_bits;
        logic [24:0]  vp8x_w;
        logic [24:0]  vp8x_h;
        logic [POS_W:0] sof_end;
        logic         long_enough;
        be_w      = {w_hdr[16], w_hdr[17], w_hdr[18], w_hdr[19]};
        be_h      = {w_hdr[20], w_hdr[21], w_hdr[22], w_hdr[23]};
        gif_w     = {w_hdr[7], w_hdr[6]};
        gif_h     = {w_hdr[9], w_hdr[8]};
        bmp_w     = {w_hdr[21], w_hdr[20], w_hdr[19], w_hdr[18]};
        bmp_raw   = {w_hdr[25], w_hdr[24], w_hdr[23], w_hdr[22]};
        bmp_h     = bmp_raw[31] ? (~bmp_raw + 32'd1) : bmp_raw;
        vp8l_bits = {w_hdr[24], w_hdr[23], w_hdr[22], w_hdr[21]};
        vp8x_w    = {1'b0, w_hdr[26], w_hdr[25], w_hdr[24]} + 25'd1;
        vp8x_h    = {1'b0, w_hdr[29], w_hdr[28], w_hdr[27]} + 25'd1;
        sof_end   = {1'b0, jpeg_stat.sof_pos} + (POS_W+1)'(SOF_SPAN);
        long_enough = n_pos >= POS_W'(MIN_BYTES);

        n_ok     = 1'b0;
        n_fmt    = FMT_NONE;
        n_width  = '0;
        n_height = '0;
        if (long_enough) begin
            if ({w_hdr[0], w_hdr[1], w_hdr[2], w_hdr[3],
                 w_hdr[4], w_hdr[5], w_hdr[6], w_hdr[7]} == SIG_PNG
                && {w_hdr[12], w_hdr[13], w_hdr[14], w_hdr[15]} == SIG_IHDR) begin
                n_fmt    = FMT_PNG;
                n_ok     = (be_w != 32'd0) && !be_w[31] && (be_h != 32'd0) && !be_h[31];
                n_width  = be_w[30:0];
                n_height = be_h[30:0];
            end else if ({w_hdr[0], w_hdr[1], w_hdr[2], w_hdr[3], w_hdr[4], w_hdr[5]}
                         == SIG_GIF7
                         || {w_hdr[0], w_hdr[1], w_hdr[2], w_hdr[3], w_hdr[4], w_hdr[5]}
                         == SIG_GIF9) begin
                n_fmt    = FMT_GIF;
                n_ok     = (gif_w != 16'd0) && (gif_h != 16'd0);
                n_width  = 31'(gif_w);
                n_height = 31'(gif_h);
            end else if ({w_hdr[0], w_hdr[1]} == SIG_BMP) begin
                n_fmt    = FMT_BMP;
                // the most negative height has no absolute value: reject it
                n_ok     = (bmp_w != 32'd0) && !bmp_w[31]
                           && (bmp_raw != 32'h8000_0000) && (bmp_raw != 32'd0);
                n_width  = bmp_w[30:0];
                n_height = bmp_h[30:0];
            end else if ({w_hdr[0], w_hdr[1]} == SIG_SOI) begin
                n_fmt    = FMT_JPEG;
                n_ok     = jpeg_stat.sof_found && !jpeg_stat.failed
                           && (sof_end <= {1'b0, n_pos})
                           && (jpeg_stat.width != 16'd0) && (jpeg_stat.height != 16'd0);
                n_width  = 31'(jpeg_stat.width);
                n_height = 31'(jpeg_stat.height);
            end else if (n_pos >= POS_W'(MIN_WEBP_BYTES)
                         && {w_hdr[0], w_hdr[1], w_hdr[2], w_hdr[3]} == SIG_RIFF
                         && {w_hdr[8], w_hdr[9], w_hdr[10], w_hdr[11]} == SIG_WEBP) begin
                n_fmt = FMT_WEBP;
                if ({w_hdr[12], w_hdr[13], w_hdr[14], w_hdr[15]} == SIG_VP8X) begin
                    n_ok     = 1'b1;
                    n_width  = 31'(vp8x_w);
                    n_height = 31'(vp8x_h);
                end else if ({w_hdr[12], w_hdr[13], w_hdr[14], w_hdr[15]} == SIG_VP8S) begin
                    n_width  = 31'({w_hdr[27], w_hdr[26]} & {2'b00, VP8_DIM_MASK});
                    n_height = 31'({w_hdr[29], w_hdr[28]} & {2'b00, VP8_DIM_MASK});
                    n_ok     = (n_width != 31'd0) && (n_height != 31'd0);
                end else if ({w_hdr[12], w_hdr[13], w_hdr[14], w_hdr[15]} == SIG_VP8L) begin
                    n_ok     = 1'b1;
                    n_width  = 31'(vp8l_bits[13:0]) + 31'd1;
                    n_height = 31'(vp8l_bits[27:14]) + 31'd1;
                end
            end
        end
        if (!n_ok) begin
            n_width  = '0;
            n_height = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_in_last) begin
            r_ok     <= n_ok;
            r_fmt    <= n_fmt;
            r_width  <= n_width;
            r_height <= n_height;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_size_ok      = r_ok;
    assign o_image_format = r_fmt;
    assign o_pixel_width  = r_width;
    assign o_pixel_height = r_height;

endmodule

`default_nettype wire
